>>> rtl/core/pei_pkg.sv
`timescale 1ns / 1ps
// Package for the polynomial easing interpolator: fixed-point constants,
// curve mode codes and the stage payload types. No dependencies.
package pei_pkg;

   localparam logic [15:0] Q_ONE  = 16'd32768;
   localparam logic [15:0] Q_HALF = 16'd16384;

   localparam logic [3:0] OP_IN_FIRST    = 4'd1;
   localparam logic [3:0] OP_OUT_FIRST   = 4'd5;
   localparam logic [3:0] OP_INOUT_FIRST = 4'd9;

   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_IN     = 2'd1;
   localparam logic [1:0] MODE_OUT    = 2'd2;
   localparam logic [1:0] MODE_INOUT  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic               low_half;
      logic [2:0]         rem;
      logic [15:0]        base;
      logic [15:0]        pw;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } shape_type;

   typedef struct packed {
      logic [15:0]        e;
      logic [15:0]        f;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } blend_type;

endpackage

>>> rtl/core/polynomial_easing_interpolator_top.sv
`timescale 1ns / 1ps
// Top level of the polynomial easing interpolator: input decode, power
// pipeline, ease finish and three lerp lanes. Depends on pei_pkg,
// pei_pow_stage and pei_lerp_lane.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | opcode, time_frac, start_*, end_*
//   rsp     | out       | rsp_valid/rsp_stall  | pos_x, pos_y, pos_z
//
// One item per cycle sustained while rsp_stall stays low; an item passes through decode, four
// power multiplies, ease finish, lerp multiply and rounded sum.
// Reset clears the stage valid bits only.
// A stalled stage holds; empty stages keep filling, so bubbles collapse and
// req_stall rises only once every stage holds an item.
module polynomial_easing_interpolator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic [15:0]        req_time_frac,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z
);
   import pei_pkg::*;

   logic        en_a;
   logic [3:0]  en_p;
   logic        en_f;
   logic        en_m;
   logic        en_o;

   logic        a_valid_ff;
   shape_type   a_item_ff;
   shape_type   a_item_in;
   logic [15:0] u;
   logic [16:0] u2;
   logic [16:0] u2_hi;

   logic [4:0]  p_valid;
   shape_type   p_item [5];

   logic        f_valid_ff;
   blend_type   f_blend_ff;
   blend_type   f_blend_in;
   logic [16:0] pw_half;
   logic [15:0] e_val;

   logic        m_valid_ff;
   logic        o_valid_ff;
   logic [7:0]  stage_valid;

   // stage enables: a stage loads when empty or when the next one loads
   assign en_o    = !o_valid_ff || !rsp_stall;
   assign en_m    = !m_valid_ff || en_o;
   assign en_f    = !f_valid_ff || en_m;
   assign en_p[3] = !p_valid[4] || en_f;
   assign en_p[2] = !p_valid[3] || en_p[3];
   assign en_p[1] = !p_valid[2] || en_p[2];
   assign en_p[0] = !p_valid[1] || en_p[1];
   assign en_a    = !a_valid_ff || en_p[0];
   assign req_stall = !en_a;

   // decode and saturate time
   assign u     = (req_time_frac > Q_ONE) ? Q_ONE : req_time_frac;
   assign u2    = {u, 1'b0};
   assign u2_hi = 17'd65536 - u2;

   always_comb begin
      a_item_in          = '0;
      a_item_in.start_x  = req_start_x;
      a_item_in.start_y  = req_start_y;
      a_item_in.start_z  = req_start_z;
      a_item_in.end_x    = req_end_x;
      a_item_in.end_y    = req_end_y;
      a_item_in.end_z    = req_end_z;
      a_item_in.low_half = (u < Q_HALF);
      a_item_in.mode     = MODE_LINEAR;
      a_item_in.rem      = 3'd0;
      a_item_in.base     = u;
      if (req_opcode >= OP_IN_FIRST && req_opcode < OP_OUT_FIRST) begin
         a_item_in.mode = MODE_IN;
         a_item_in.rem  = req_opcode[2:0];
      end else if (req_opcode >= OP_OUT_FIRST && req_opcode < OP_INOUT_FIRST) begin
         a_item_in.mode = MODE_OUT;
         a_item_in.rem  = 3'(req_opcode - (OP_OUT_FIRST - 4'd1));
         a_item_in.base = Q_ONE - u;
      end else if (req_opcode >= OP_INOUT_FIRST
                   && req_opcode < OP_INOUT_FIRST + 4'd4) begin
         a_item_in.mode = MODE_INOUT;
         a_item_in.rem  = 3'(req_opcode - (OP_INOUT_FIRST - 4'd1));
         a_item_in.base = (u < Q_HALF) ? u2[15:0] : u2_hi[15:0];
      end
      a_item_in.pw = a_item_in.base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_a) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_item_ff <= a_item_in;
      end
   end

   // power pipeline
   assign p_valid[0] = a_valid_ff;
   assign p_item[0]  = a_item_ff;

   for (genvar i = 0; i < 4; i++) begin : g_pow
      pei_pow_stage u_pow (
         .clock     (clock),
         .reset     (reset),
         .en        (en_p[i]),
         .in_valid  (p_valid[i]),
         .in_item   (p_item[i]),
         .out_valid (p_valid[i+1]),
         .out_item  (p_item[i+1])
      );
   end

   // ease finish
   assign pw_half = ({1'b0, p_item[4].pw} + 17'd1) >> 1;

   always_comb begin
      unique case (p_item[4].mode)
         MODE_LINEAR, MODE_IN: e_val = p_item[4].pw;
         MODE_OUT:             e_val = Q_ONE - p_item[4].pw;
         MODE_INOUT: begin
            e_val = p_item[4].low_half ? pw_half[15:0] : Q_ONE - pw_half[15:0];
         end
         default:              e_val = p_item[4].pw;
      endcase
   end

   always_comb begin
      f_blend_in.e       = e_val;
      f_blend_in.f       = Q_ONE - e_val;
      f_blend_in.start_x = p_item[4].start_x;
      f_blend_in.start_y = p_item[4].start_y;
      f_blend_in.start_z = p_item[4].start_z;
      f_blend_in.end_x   = p_item[4].end_x;
      f_blend_in.end_y   = p_item[4].end_y;
      f_blend_in.end_z   = p_item[4].end_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (en_f) begin
            f_valid_ff <= p_valid[4];
         end
         if (en_m) begin
            m_valid_ff <= f_valid_ff;
         end
         if (en_o) begin
            o_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_f) begin
         f_blend_ff <= f_blend_in;
      end
   end

   // lerp lanes
   pei_lerp_lane u_lane_x (
      .clock    (clock),
      .en_mul   (en_m),
      .en_sum   (en_o),
      .start_pt (f_blend_ff.start_x),
      .end_pt   (f_blend_ff.end_x),
      .e        (f_blend_ff.e),
      .f        (f_blend_ff.f),
      .pos      (rsp_pos_x)
   );

   pei_lerp_lane u_lane_y (
      .clock    (clock),
      .en_mul   (en_m),
      .en_sum   (en_o),
      .start_pt (f_blend_ff.start_y),
      .end_pt   (f_blend_ff.end_y),
      .e        (f_blend_ff.e),
      .f        (f_blend_ff.f),
      .pos      (rsp_pos_y)
   );

   pei_lerp_lane u_lane_z (
      .clock    (clock),
      .en_mul   (en_m),
      .en_sum   (en_o),
      .start_pt (f_blend_ff.start_z),
      .end_pt   (f_blend_ff.end_z),
      .e        (f_blend_ff.e),
      .f        (f_blend_ff.f),
      .pos      (rsp_pos_z)
   );

   assign rsp_valid   = o_valid_ff;
   assign stage_valid = {o_valid_ff, m_valid_ff, f_valid_ff, p_valid};

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid == 8'hFF))
      else $error("input stalled while a stage is empty");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   a_transfer_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> a_valid_ff)
      else $error("accepted transfer missing from first stage");

   a_held_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && m_valid_ff) |=> m_valid_ff && rsp_valid)
      else $error("stage item lost under stall");
`endif

endmodule

>>> rtl/core/pei_pow_stage.sv
`timescale 1ns / 1ps
// One power step of the easing curve: a registered Q1.15 multiply by the base
// while steps remain. Depends on pei_pkg.
module pei_pow_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  pei_pkg::shape_type in_item,
   output logic               out_valid,
   output pei_pkg::shape_type out_item
);
   import pei_pkg::*;

   logic       valid_ff;
   shape_type  item_ff;
   shape_type  item_in;
   logic [31:0] prod;
   logic [31:0] prod_rnd;

   assign prod     = in_item.pw * in_item.base;
   assign prod_rnd = prod + {16'd0, Q_HALF};

   always_comb begin
      item_in = in_item;
      if (in_item.rem != 3'd0) begin
         item_in.pw  = prod_rnd[30:15];
         item_in.rem = in_item.rem - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/core/pei_lerp_lane.sv
`timescale 1ns / 1ps
// One interpolation lane: registered weight products, then a rounded sum
// back to Q16.16. No package dependency.
module pei_lerp_lane (
   input  logic               clock,
   input  logic               en_mul,
   input  logic               en_sum,
   input  logic signed [31:0] start_pt,
   input  logic signed [31:0] end_pt,
   input  logic [15:0]        e,
   input  logic [15:0]        f,
   output logic signed [31:0] pos
);

   logic signed [48:0] prod_s_full;
   logic signed [48:0] prod_e_full;
   logic signed [47:0] prod_s_ff;
   logic signed [47:0] prod_e_ff;
   logic signed [47:0] sum;
   logic signed [31:0] pos_ff;
   logic signed [31:0] pos_in;

   assign prod_s_full = start_pt * $signed({1'b0, f});
   assign prod_e_full = end_pt * $signed({1'b0, e});

   assign sum    = prod_s_ff + prod_e_ff + 48'sd16384;
   assign pos_in = sum[46:15];

   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_s_ff <= prod_s_full[47:0];
         prod_e_ff <= prod_e_full[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

>>> test/tb_polynomial_easing_interpolator_top.sv
`timescale 1ns / 1ps
// Self-checking bench for polynomial_easing_interpolator_top: drives eased lerp requests in
// random bursts against a stalling receiver and checks every transfer against its own
// predictor held in a small scoreboard class. Depends on pei_pkg and the RTL under rtl/.
module tb_polynomial_easing_interpolator_top;
   import pei_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 750;
   localparam int DRAIN_CYCLES  = 16;

   localparam logic [3:0] OP_LINEAR     = 4'd0;
   localparam logic [3:0] OP_INOUT_LAST = 4'd12;
   localparam logic [3:0] OP_CODE_MAX   = 4'd15;

   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic [3:0]         opcode;
      logic [15:0]        time_frac;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } easing_request_type;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } easing_position_type;

   class easing_scoreboard;
      easing_position_type expected_positions[$];
      int unsigned         mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int unsigned scaled_power(int unsigned base, int unsigned degree);
         longint unsigned p;
         p = base;
         for (int unsigned i = 1; i < degree; i++)
            p = (p * base + Q_HALF) >> 15;
         return 32'(p);
      endfunction

      function int unsigned eased_fraction(logic [3:0] op, logic [15:0] tf);
         int unsigned one;
         int unsigned u;
         one = Q_ONE;
         u = (tf > Q_ONE) ? one : tf;
         if (op >= OP_IN_FIRST && op < OP_OUT_FIRST)
            return scaled_power(u, op - OP_IN_FIRST + 2);
         if (op >= OP_OUT_FIRST && op < OP_INOUT_FIRST)
            return one - scaled_power(one - u, op - OP_OUT_FIRST + 2);
         if (op >= OP_INOUT_FIRST && op <= OP_INOUT_LAST) begin
            if (u < Q_HALF)
               return (scaled_power(2 * u, op - OP_INOUT_FIRST + 2) + 1) >> 1;
            return one - ((scaled_power(2 * one - 2 * u, op - OP_INOUT_FIRST + 2) + 1) >> 1);
         end
         return u;
      endfunction

      function logic signed [31:0] blend_lane(logic signed [31:0] s, logic signed [31:0] d,
                                              int unsigned e);
         longint sum;
         sum = longint'(s) * (longint'(Q_ONE) - longint'(e)) + longint'(d) * longint'(e);
         return 32'((sum + 16384) >>> 15);
      endfunction

      function void note_request(easing_request_type r);
         easing_position_type p;
         int unsigned         e;
         e = eased_fraction(r.opcode, r.time_frac);
         p.pos_x = blend_lane(r.start_x, r.end_x, e);
         p.pos_y = blend_lane(r.start_y, r.end_y, e);
         p.pos_z = blend_lane(r.start_z, r.end_z, e);
         expected_positions.push_back(p);
      endfunction

      function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
         easing_position_type p;
         if (expected_positions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: %0d %0d %0d", x, y, z);
         end else begin
            p = expected_positions.pop_front();
            if (p.pos_x !== x || p.pos_y !== y || p.pos_z !== z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           p.pos_x, p.pos_y, p.pos_z, x, y, z);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_positions.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_opcode = '0;
   logic [15:0]        req_time_frac = '0;
   logic signed [31:0] req_start_x = '0;
   logic signed [31:0] req_start_y = '0;
   logic signed [31:0] req_start_z = '0;
   logic signed [31:0] req_end_x = '0;
   logic signed [31:0] req_end_y = '0;
   logic signed [31:0] req_end_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [31:0] rsp_pos_z;

   logic [11:0]        stall_phase = '0;
   easing_scoreboard   sb;

   polynomial_easing_interpolator_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_time_frac (req_time_frac),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_start_z   (req_start_z),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_end_z     (req_end_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[9:8])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_phase[2:0] < 3'd3);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_pos_x, rsp_pos_y, rsp_pos_z);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   task automatic send_transfer(input easing_request_type r);
      req_valid     <= 1'b1;
      req_opcode    <= r.opcode;
      req_time_frac <= r.time_frac;
      req_start_x   <= r.start_x;
      req_start_y   <= r.start_y;
      req_start_z   <= r.start_z;
      req_end_x     <= r.end_x;
      req_end_y     <= r.end_y;
      req_end_z     <= r.end_z;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_request(r);
   endtask

   task automatic idle_cycles(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   function automatic easing_request_type random_request();
      easing_request_type r;
      r.opcode = 4'($urandom_range(0, OP_CODE_MAX));
      case ($urandom_range(0, 9))
         0: r.time_frac = 16'($urandom);
         1: r.time_frac = 16'($urandom_range(Q_HALF - 4, Q_HALF + 4));
         2: r.time_frac = 16'($urandom_range(Q_ONE - 8, Q_ONE + 2));
         3: r.time_frac = 16'($urandom_range(0, 8));
         default: r.time_frac = 16'($urandom_range(0, Q_ONE));
      endcase
      r.start_x = random_coord();
      r.start_y = random_coord();
      r.start_z = random_coord();
      r.end_x   = random_coord();
      r.end_y   = random_coord();
      r.end_z   = random_coord();
      return r;
   endfunction

   initial begin
      logic [15:0]        special_times [8];
      easing_request_type r;
      int unsigned        sent;
      int unsigned        burst;
      int unsigned        gap;

      special_times = '{16'd0, 16'd1, 16'd16383, 16'd16384, 16'd16385,
                        16'd32767, 16'd32768, 16'd65535};
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i <= OP_CODE_MAX; i++) begin
         r.opcode    = 4'(i);
         r.time_frac = special_times[i % 8];
         r.start_x   = i[0] ? COORD_MIN : COORD_MAX;
         r.end_x     = i[0] ? COORD_MAX : COORD_MIN;
         r.start_y   = i[1] ? '0 : COORD_MIN;
         r.end_y     = i[1] ? COORD_MIN : COORD_MAX;
         r.start_z   = i[2] ? -32'sd1 : 32'sd65536;
         r.end_z     = i[2] ? COORD_MAX : -32'sd65536;
         send_transfer(r);
      end
      for (int i = 0; i < 8; i++) begin
         r.opcode    = OP_INOUT_FIRST + 4'(i % 4);
         r.time_frac = special_times[7 - i];
         r.start_x   = COORD_MAX;
         r.end_x     = COORD_MAX;
         r.start_y   = COORD_MIN;
         r.end_y     = COORD_MIN;
         r.start_z   = (i < 4) ? COORD_MIN : '0;
         r.end_z     = (i < 4) ? COORD_MAX : '0;
         if (i == 7)
            r.opcode = OP_LINEAR;
         send_transfer(r);
      end
      idle_cycles(3);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_transfer(random_request());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0)
            idle_cycles(gap);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
